@@ sv/sms_pkg.sv @@
// Shared types and constants of the stagnation mutation scheduler.
package sms_pkg;

    localparam int GEN_W   = 24;
    localparam int SCORE_W = 32;
    localparam int Q16_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_AMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_AMP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_LIMIT  = 3'd5;

    localparam logic [Q16_W-1:0] RST_COARSE_THR = 16'd13107;
    localparam logic [Q16_W-1:0] RST_FINE_THR   = 16'd1311;
    localparam logic [Q16_W-1:0] RST_STOP_THR   = 16'd655;
    localparam logic [Q16_W-1:0] RST_LARGE_AMP  = 16'd13107;
    localparam logic [Q16_W-1:0] RST_SMALL_AMP  = 16'd2621;
    localparam logic [GEN_W-1:0] RST_GEN_LIMIT  = 24'd1000;

    typedef enum logic [1:0] {
        PH_COARSE = 2'd0,
        PH_FINE   = 2'd1,
        PH_FINEST = 2'd2
    } t_phase;

endpackage

@@ sv/sms_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 250
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/stagnation_mutation_scheduler.sv @@
// Top level of the stagnation mutation scheduler.
// Path from input transfer to output valid: input register, stage b slot register, registered
// ring read, output register; one item per cycle while the output is not stalled.
// The phase/window update in the compare stage is the recurrence that limits the rate.
// Four pipeline slots decouple input from output; input stalls only when all are full.
// Synchronous active-low reset clears pipeline, phase, window count and loads
// register defaults; the score ring is not cleared.
module stagnation_mutation_scheduler
    import sms_pkg::*;
#(
    parameter int WINDOW_DEPTH = 250
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [23:0] generation_number, [55:24] best_score
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] stop_request, [1] absolute_mutation, [17:2] mutation_amplitude,
    // [19:18] schedule_phase, [23:20] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int CW     = $clog2(WINDOW_DEPTH + 1);
    localparam int SHIFT  = GEN_W + AW;
    localparam int RECIP_W = GEN_W + 2;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = GEN_W + RECIP_W;

    // configuration
    logic [Q16_W-1:0] r_coarse_thr, r_fine_thr, r_stop_thr, r_large_amp, r_small_amp;
    logic [GEN_W-1:0] r_gen_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse_thr <= RST_COARSE_THR;
            r_fine_thr   <= RST_FINE_THR;
            r_stop_thr   <= RST_STOP_THR;
            r_large_amp  <= RST_LARGE_AMP;
            r_small_amp  <= RST_SMALL_AMP;
            r_gen_limit  <= RST_GEN_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COARSE_THR: r_coarse_thr <= i_cfg_data[Q16_W-1:0];
                CFG_FINE_THR:   r_fine_thr   <= i_cfg_data[Q16_W-1:0];
                CFG_STOP_THR:   r_stop_thr   <= i_cfg_data[Q16_W-1:0];
                CFG_LARGE_AMP:  r_large_amp  <= i_cfg_data[Q16_W-1:0];
                CFG_SMALL_AMP:  r_small_amp  <= i_cfg_data[Q16_W-1:0];
                CFG_GEN_LIMIT:  r_gen_limit  <= i_cfg_data[GEN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_va, r_vb, r_vc, r_vo;
    logic adv_a, adv_b, adv_c, adv_o;
    logic en_a, en_b, en_c;

    assign adv_o = r_vc && (!r_vo || i_m_tready);
    assign en_c  = !r_vc || adv_o;
    assign adv_c = r_vb && en_c;
    assign en_b  = !r_vb || adv_c;
    assign adv_b = r_va && en_b;
    assign en_a  = !r_va || adv_b;
    assign adv_a = i_s_tvalid && en_a;
    assign o_s_tready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_a) r_va <= i_s_tvalid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (adv_o) begin
                r_vo <= 1'b1;
            end else if (i_m_tready) begin
                r_vo <= 1'b0;
            end
        end
    end

    // stage a: input register, reciprocal multiply for the ring slot
    logic [GEN_W-1:0]   r_a_gen, r_b_gen, r_c_gen;
    logic [SCORE_W-1:0] r_a_score, r_b_score, r_c_score;
    logic [GEN_W-1:0]   r_b_q;
    logic [PROD_W-1:0]  recip_prod;

    assign recip_prod = PROD_W'(r_a_gen) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_gen   <= i_s_tdata[GEN_W-1:0];
            r_a_score <= i_s_tdata[GEN_W +: SCORE_W];
        end
        if (adv_b) begin
            r_b_gen   <= r_a_gen;
            r_b_score <= r_a_score;
            r_b_q     <= GEN_W'(recip_prod >> SHIFT);
        end
        if (adv_c) begin
            r_c_gen   <= r_b_gen;
            r_c_score <= r_b_score;
        end
    end

    // stage b: ring write at this slot, read of the oldest slot
    logic [GEN_W-1:0]   q_times_w;
    logic [AW-1:0]      slot_pos, slot_nxt;
    logic [SCORE_W-1:0] old_score;

    assign q_times_w = GEN_W'(r_b_q * GEN_W'(WINDOW_DEPTH));
    assign slot_pos  = AW'(r_b_gen - q_times_w);
    assign slot_nxt  = (slot_pos == AW'(WINDOW_DEPTH - 1)) ? '0 : AW'(slot_pos + 1'b1);

    sms_ram #(
        .WIDTH(SCORE_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (adv_c),
        .i_waddr (slot_pos),
        .i_wdata (r_b_score),
        .i_re    (adv_c),
        .i_raddr (slot_nxt),
        .o_rdata (old_score)
    );

    // stage c: improvement test and schedule update
    t_phase            r_phase, ph0, n_phase;
    logic [CW-1:0]     r_wc, wc0, n_wc;
    logic              n_stop;
    logic [Q16_W-1:0]  thr;
    logic [Q16_W+SCORE_W-1:0] thr_prod;
    logic signed [SCORE_W:0]  diff;
    logic signed [SCORE_W+Q16_W:0] lhs, rhs;
    logic              below;
    logic              gen_zero;

    assign gen_zero = (r_c_gen == '0);
    assign ph0      = gen_zero ? PH_COARSE : r_phase;
    assign wc0      = gen_zero ? '0 : r_wc;

    always_comb begin
        unique case (ph0)
            PH_COARSE: thr = r_coarse_thr;
            PH_FINE:   thr = r_fine_thr;
            default:   thr = r_stop_thr;
        endcase
    end

    assign thr_prod = (Q16_W+SCORE_W)'(thr) * (Q16_W+SCORE_W)'(r_c_score);
    assign diff     = $signed({1'b0, old_score}) - $signed({1'b0, r_c_score});
    assign lhs      = $signed({diff, {Q16_W{1'b0}}});
    assign rhs      = $signed({1'b0, thr_prod});
    assign below    = lhs < rhs;

    always_comb begin
        n_phase = ph0;
        n_wc    = wc0;
        n_stop  = 1'b0;
        if (wc0 == CW'(WINDOW_DEPTH) && below) begin
            unique case (ph0)
                PH_COARSE: begin
                    n_phase = PH_FINE;
                    n_wc    = '0;
                end
                PH_FINE: begin
                    n_phase = PH_FINEST;
                    n_wc    = '0;
                end
                default: n_stop = 1'b1;
            endcase
        end
        if (n_wc < CW'(WINDOW_DEPTH)) begin
            n_wc = CW'(n_wc + 1'b1);
        end
        if (r_c_gen >= r_gen_limit) begin
            n_stop = 1'b1;
        end
    end

    logic             n_abs;
    logic [Q16_W-1:0] n_amp;

    always_comb begin
        n_abs = (n_phase == PH_COARSE);
        n_amp = (n_phase == PH_FINEST) ? r_small_amp : r_large_amp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COARSE;
            r_wc    <= '0;
        end else if (adv_o) begin
            r_phase <= n_phase;
            r_wc    <= n_wc;
        end
    end

    // output register
    logic             r_o_stop, r_o_abs;
    logic [Q16_W-1:0] r_o_amp;
    t_phase           r_o_phase;

    always_ff @(posedge i_clk) begin
        if (adv_o) begin
            r_o_stop  <= n_stop;
            r_o_abs   <= n_abs;
            r_o_amp   <= n_amp;
            r_o_phase <= n_phase;
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {4'b0000, r_o_phase, r_o_amp, r_o_abs, r_o_stop};

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_c |-> (slot_pos < AW'(WINDOW_DEPTH - 1) || slot_pos == AW'(WINDOW_DEPTH - 1)))
        else $error("ring slot out of range");
    a_wc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= CW'(WINDOW_DEPTH))
        else $error("window count above depth");
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv_o |=> $stable(r_phase) && $stable(r_wc))
        else $error("schedule state changed without transfer");
    a_phase_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_o && !gen_zero) |=> r_phase >= $past(r_phase))
        else $error("phase went back without generation zero");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_va && r_vb && r_vc && r_vo))
        else $error("input stalled with a free slot");
`endif

endmodule

@@ test/stagnation_mutation_scheduler_test.sv @@
// Self-checking stream testbench for the stagnation mutation scheduler.
module stagnation_mutation_scheduler_test;
    import sms_pkg::*;

    localparam int WINDOW       = 250;
    localparam int SEGMENTS     = 6;
    localparam int SEG_ITEMS    = 250;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic               hold_for_drain;
        logic [SCORE_W-1:0] score;
        logic [GEN_W-1:0]   gen;
    } t_gen_item;

    typedef struct packed {
        logic             stop;
        logic             abs_mut;
        logic [Q16_W-1:0] amplitude;
        t_phase           phase;
    } t_schedule;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    stagnation_mutation_scheduler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Scheduler shadow state
    logic [SCORE_W-1:0] score_ring [WINDOW];
    int                 window_fill = 0;
    t_phase             sched_phase = PH_COARSE;
    logic [Q16_W-1:0]   coarse_thr = RST_COARSE_THR;
    logic [Q16_W-1:0]   fine_thr   = RST_FINE_THR;
    logic [Q16_W-1:0]   stop_thr   = RST_STOP_THR;
    logic [Q16_W-1:0]   large_amp  = RST_LARGE_AMP;
    logic [Q16_W-1:0]   small_amp  = RST_SMALL_AMP;
    logic [GEN_W-1:0]   gen_limit  = RST_GEN_LIMIT;

    t_gen_item pending_items [$];
    t_schedule predicted [$];

    int fail_count  = 0;
    int cycle_count = 0;
    int tx_idle_pct = 17;
    int rx_idle_pct = 60;

    logic                 s_ready_smp = 1'b0;
    logic                 m_valid_smp = 1'b0;
    logic [M_TDATA_W-1:0] m_data_smp = '0;
    logic                 cfg_ready_smp = 1'b0;

    // (old - cur) / cur < thr / 2^16, cross-multiplied
    function automatic bit improvement_low(input logic [SCORE_W-1:0] oldv,
                                           input logic [SCORE_W-1:0] cur,
                                           input logic [Q16_W-1:0] thr);
        longint o, c, t;
        o = oldv;
        c = cur;
        t = thr;
        return ((o - c) * 65536) < (t * c);
    endfunction

    function automatic t_schedule schedule_step(input logic [GEN_W-1:0] gen,
                                                input logic [SCORE_W-1:0] score);
        t_schedule r;
        logic [SCORE_W-1:0] oldest;
        if (gen == 0) begin
            sched_phase = PH_COARSE;
            window_fill = 0;
        end
        score_ring[gen % WINDOW] = score;
        r.stop = 1'b0;
        if (window_fill >= WINDOW) begin
            oldest = score_ring[(gen + 1) % WINDOW];
            if (sched_phase == PH_COARSE) begin
                if (improvement_low(oldest, score, coarse_thr)) begin
                    sched_phase = PH_FINE;
                    window_fill = 0;
                end
            end else if (sched_phase == PH_FINE) begin
                if (improvement_low(oldest, score, fine_thr)) begin
                    sched_phase = PH_FINEST;
                    window_fill = 0;
                end
            end else if (improvement_low(oldest, score, stop_thr)) begin
                r.stop = 1'b1;
            end
        end
        if (window_fill < WINDOW) window_fill++;
        if (gen >= gen_limit) r.stop = 1'b1;
        r.abs_mut   = (sched_phase == PH_COARSE);
        r.amplitude = (sched_phase == PH_FINEST) ? small_amp : large_amp;
        r.phase     = sched_phase;
        return r;
    endfunction

    task automatic queue_item(input logic [GEN_W-1:0] gen, input logic [SCORE_W-1:0] score,
                              input logic hold);
        t_gen_item it;
        it.gen            = gen;
        it.score          = score;
        it.hold_for_drain = hold;
        pending_items.push_back(it);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready_smp);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_COARSE_THR: coarse_thr = val[Q16_W-1:0];
            CFG_FINE_THR:   fine_thr   = val[Q16_W-1:0];
            CFG_STOP_THR:   stop_thr   = val[Q16_W-1:0];
            CFG_LARGE_AMP:  large_amp  = val[Q16_W-1:0];
            CFG_SMALL_AMP:  small_amp  = val[Q16_W-1:0];
            CFG_GEN_LIMIT:  gen_limit  = val[GEN_W-1:0];
            default: ;
        endcase
    endtask

    // checked mid-cycle, after the driver and monitor have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || predicted.size() != 0 || i_s_tvalid);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        s_ready_smp   <= o_s_tready;
        m_valid_smp   <= o_m_tvalid;
        m_data_smp    <= o_m_tdata;
        cfg_ready_smp <= o_cfg_ready;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Generation driver
    always @(posedge i_clk) begin : gen_driver
        t_gen_item in_flight;
        bit send;
        if (i_s_tvalid && s_ready_smp)
            predicted.push_back(schedule_step(in_flight.gen, in_flight.score));
        if (!i_s_tvalid || s_ready_smp) begin
            send = i_rst_n && pending_items.size() != 0
                   && $urandom_range(0, 99) >= tx_idle_pct;
            if (send && pending_items[0].hold_for_drain && predicted.size() != 0)
                send = 1'b0;
            if (send) begin
                in_flight = pending_items.pop_front();
                i_s_tdata <= {in_flight.score, in_flight.gen};
            end
            i_s_tvalid <= send;
        end
    end

    // Schedule monitor
    always @(posedge i_clk) begin : schedule_monitor
        t_schedule want;
        if (m_valid_smp && i_m_tready) begin
            if (predicted.size() == 0) begin
                $error("unexpected result transfer: %h", m_data_smp);
                fail_count++;
            end else begin
                want = predicted.pop_front();
                if (m_data_smp[0] !== want.stop) begin
                    $error("stop_request: expected %0d, got %0d", want.stop, m_data_smp[0]);
                    fail_count++;
                end
                if (m_data_smp[1] !== want.abs_mut) begin
                    $error("absolute_mutation: expected %0d, got %0d",
                           want.abs_mut, m_data_smp[1]);
                    fail_count++;
                end
                if (m_data_smp[17:2] !== want.amplitude) begin
                    $error("mutation_amplitude: expected %0d, got %0d",
                           want.amplitude, m_data_smp[17:2]);
                    fail_count++;
                end
                if (m_data_smp[19:18] !== want.phase) begin
                    $error("schedule_phase: expected %0d, got %0d",
                           want.phase, m_data_smp[19:18]);
                    fail_count++;
                end
            end
        end
        i_m_tready <= i_rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial begin : stimulus
        logic [GEN_W-1:0]   run_gen, gen, prev_gen;
        logic [SCORE_W-1:0] level, score;
        int run_end, decay, warmup, roll, seg, k;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, generation limit edge, ring wrap, restarts
        queue_item(24'd0, 32'd0, 1'b0);
        queue_item(24'd1, 32'hFFFF_FFFF, 1'b0);
        queue_item(24'd2, 32'hAAAA_AAAA, 1'b0);
        queue_item(24'd3, 32'h5555_5555, 1'b0);
        queue_item(24'hAAAAAA, 32'h0000_0001, 1'b0);
        queue_item(24'h555555, 32'h8000_0000, 1'b0);
        queue_item(24'hFFFFFF, $urandom(), 1'b0);
        queue_item(24'd999, $urandom(), 1'b0);
        queue_item(24'd1000, $urandom(), 1'b0);
        queue_item(24'd1001, $urandom(), 1'b0);
        queue_item(24'd0, 32'h7FFF_FFFF, 1'b0);
        queue_item(24'd249, $urandom(), 1'b0);
        queue_item(24'd250, $urandom(), 1'b0);
        queue_item(24'd251, $urandom(), 1'b0);
        queue_item(24'd0, 32'h1234_5678, 1'b1);

        // the first WINDOW + 10 items are strictly sequential so every ring slot is written before any read
        run_gen  = '0;
        prev_gen = '0;
        run_end  = $urandom_range(600, 900);
        warmup   = WINDOW + 10;
        level    = $urandom_range(32'hFFFF_FFFF, 32'h0001_0000);
        decay    = $urandom_range(5, 20);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            wait_idle();
            case (seg)
                1: begin
                    write_register(CFG_COARSE_THR, 24'hFFFFFF);
                    write_register(CFG_FINE_THR, 24'h00FFFF);
                    write_register(CFG_STOP_THR, 24'h00FFFF);
                    write_register(CFG_LARGE_AMP, 24'h00FFFF);
                    write_register(CFG_SMALL_AMP, 24'h000000);
                    write_register(CFG_GEN_LIMIT, 24'hFFFFFF);
                    write_register(CFG_SPARE_LO, 24'($urandom()));
                end
                2: begin
                    write_register(CFG_COARSE_THR, 24'h000000);
                    write_register(CFG_FINE_THR, 24'h000000);
                    write_register(CFG_STOP_THR, 24'hFF0000);
                    write_register(CFG_LARGE_AMP, 24'h000000);
                    write_register(CFG_SMALL_AMP, 24'hFFFFFF);
                    write_register(CFG_GEN_LIMIT, 24'h000000);
                    write_register(CFG_SPARE_HI, 24'($urandom()));
                end
                3: begin
                    write_register(CFG_COARSE_THR, 24'($urandom_range(0, 26000)));
                    write_register(CFG_FINE_THR, 24'($urandom_range(0, 2600)));
                    write_register(CFG_STOP_THR, 24'($urandom_range(0, 1300)));
                    write_register(CFG_LARGE_AMP, 24'($urandom()));
                    write_register(CFG_SMALL_AMP, 24'($urandom()));
                    write_register(CFG_GEN_LIMIT, 24'($urandom_range(400, 1200)));
                end
                4: begin
                    write_register(CFG_COARSE_THR, CFG_DATA_W'(RST_COARSE_THR));
                    write_register(CFG_FINE_THR, CFG_DATA_W'(RST_FINE_THR));
                    write_register(CFG_STOP_THR, CFG_DATA_W'(RST_STOP_THR));
                    write_register(CFG_LARGE_AMP, CFG_DATA_W'(RST_LARGE_AMP));
                    write_register(CFG_SMALL_AMP, CFG_DATA_W'(RST_SMALL_AMP));
                    write_register(CFG_GEN_LIMIT, CFG_DATA_W'(RST_GEN_LIMIT));
                end
                5: begin
                    write_register(CFG_COARSE_THR, 24'($urandom()));
                    write_register(CFG_FINE_THR, 24'($urandom()));
                    write_register(CFG_STOP_THR, 24'($urandom()));
                    write_register(CFG_LARGE_AMP, 24'($urandom()));
                    write_register(CFG_SMALL_AMP, 24'($urandom()));
                    write_register(CFG_GEN_LIMIT, 24'($urandom()));
                end
                default: ;
            endcase

            case (seg / 2)
                0: begin tx_idle_pct = 17; rx_idle_pct = 60; end
                1: begin tx_idle_pct = 60; rx_idle_pct = 17; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase

            for (k = 0; k < SEG_ITEMS; k++) begin
                if (warmup == 0 && run_gen >= run_end) begin
                    run_gen = '0;
                    run_end = $urandom_range(300, 900);
                    level   = $urandom_range(32'hFFFF_FFFF, 32'h0001_0000);
                end
                // decay shift sets the per-window improvement; high shifts stagnate
                if ($urandom_range(0, 63) == 0) decay = $urandom_range(5, 20);
                level = level - (level >> decay);
                gen   = run_gen;
                score = level + $urandom_range(0, level >> 16);
                roll  = $urandom_range(0, 99);
                if (roll < 3)
                    score = $urandom();
                else if (roll < 5)
                    score = '0;
                else if (warmup == 0 && roll < 8)
                    gen = 24'($urandom());
                else if (warmup == 0 && roll < 10)
                    gen = prev_gen;
                if (gen == run_gen) run_gen = run_gen + 1'b1;
                if (warmup > 0) warmup--;
                prev_gen = gen;
                queue_item(gen, score, k == SEG_ITEMS / 2);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
